>>> hdl/rcfp_pkg.sv
// Shared types, character codes and register indexes for the remote command frame parser.
package rcfp_pkg;

    localparam int VALUE_BITS = 14;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [VALUE_BITS-1:0] DEADBAND_LOW_RESET = 14'd45;
    localparam logic [VALUE_BITS-1:0] DEADBAND_HIGH_RESET = 14'd55;
    localparam logic [VALUE_BITS-1:0] DEADBAND_CENTER_RESET = 14'd50;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEADBAND_LOW = 2'd0,
        CFG_DEADBAND_HIGH = 2'd1,
        CFG_DEADBAND_CENTER = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        JOY_COL_START = 3'd0,
        JOY_COL_DIGITS = 3'd1,
        JOY_ROW_START = 3'd2,
        JOY_ROW_DIGITS = 3'd3,
        JOY_MISS_NONE = 3'd4,
        JOY_MISS_COL = 3'd5,
        JOY_BOTH = 3'd6
    } joy_phase_t;

    typedef enum logic [1:0] {
        PUMP_START = 2'd0,
        PUMP_DIGITS = 2'd1,
        PUMP_MISS = 2'd2,
        PUMP_FINISHED = 2'd3
    } pump_phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } byte_item_t;

    typedef struct packed {
        logic                  joy_done;
        logic [VALUE_BITS-1:0] col_value;
        logic [VALUE_BITS-1:0] row_value;
        logic                  pump_done;
        logic [VALUE_BITS-1:0] pump_value;
    } result_item_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

endpackage

>>> hdl/rcfp_byte_if.sv
// Channel that carries received bytes into the parser.
interface rcfp_byte_if;
    logic                     valid;
    logic                     ready;
    rcfp_pkg::byte_item_t     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/rcfp_result_if.sv
// Channel that carries parsed frame results out of the parser.
interface rcfp_result_if;
    logic                     valid;
    logic                     ready;
    rcfp_pkg::result_item_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/rcfp_joy_track.sv
// Joystick frame tracker: frame length, field matching and held column and row values.
module rcfp_joy_track #(
    parameter int FRAME_LIMIT = 31,
    parameter int VALUE_MAX = 9999,
    localparam int LW = $clog2(FRAME_LIMIT + 1),
    localparam int VW = $clog2(VALUE_MAX + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output logic          done,
    output logic [VW-1:0] col_held_next,
    output logic [VW-1:0] row_held_next
);

    localparam logic [LW-1:0] LEN_LIMIT = LW'(FRAME_LIMIT);
    localparam logic [VW+3:0] SUM_MAX = (VW + 4)'(VALUE_MAX);

    function automatic logic [VW-1:0] acc_step(input logic [VW-1:0] acc,
                                               input logic [7:0] b);
        logic [VW+3:0] sum;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VW{1'b0}}, b[3:0]};
        return (sum > SUM_MAX) ? VW'(VALUE_MAX) : sum[VW-1:0];
    endfunction

    logic                 active_reg, active_next;
    logic [LW-1:0]        length_reg, length_next;
    rcfp_pkg::joy_phase_t phase_reg, phase_next;
    logic [VW-1:0]        col_accum_reg, col_accum_next;
    logic [VW-1:0]        row_accum_reg, row_accum_next;
    logic [VW-1:0]        col_held_reg;
    logic [VW-1:0]        row_held_reg;
    logic                 digit;
    logic                 in_frame;

    assign digit = rcfp_pkg::is_digit(rx_byte);
    assign in_frame = step && active_reg && (length_reg < LEN_LIMIT);

    // Frame control and field matching phase.
    always_comb
    begin
        active_next = active_reg;
        length_next = length_reg;
        phase_next = phase_reg;
        done = 1'b0;
        if (step)
        begin
            if (!active_reg)
            begin
                if (rx_byte == rcfp_pkg::CHAR_A)
                begin
                    active_next = 1'b1;
                    length_next = LW'(1);
                    phase_next = rcfp_pkg::JOY_COL_START;
                end
            end
            else if (length_reg >= LEN_LIMIT)
            begin
                active_next = 1'b0;
                length_next = '0;
            end
            else if (rx_byte == rcfp_pkg::CHAR_Z)
            begin
                active_next = 1'b0;
                length_next = '0;
                done = 1'b1;
            end
            else
            begin
                length_next = length_reg + LW'(1);
                case (phase_reg)
                    rcfp_pkg::JOY_COL_START:
                        phase_next = digit ? rcfp_pkg::JOY_COL_DIGITS : rcfp_pkg::JOY_MISS_NONE;
                    rcfp_pkg::JOY_COL_DIGITS:
                        if (!digit)
                        begin
                            phase_next = (rx_byte == rcfp_pkg::CHAR_COMMA) ?
                                         rcfp_pkg::JOY_ROW_START : rcfp_pkg::JOY_MISS_COL;
                        end
                    rcfp_pkg::JOY_ROW_START:
                        phase_next = digit ? rcfp_pkg::JOY_ROW_DIGITS : rcfp_pkg::JOY_MISS_COL;
                    rcfp_pkg::JOY_ROW_DIGITS:
                        if (!digit)
                        begin
                            phase_next = rcfp_pkg::JOY_BOTH;
                        end
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // Digit accumulation and held values.
    always_comb
    begin
        col_accum_next = col_accum_reg;
        row_accum_next = row_accum_reg;
        col_held_next = col_held_reg;
        row_held_next = row_held_reg;
        if (step && !active_reg && (rx_byte == rcfp_pkg::CHAR_A))
        begin
            col_accum_next = '0;
            row_accum_next = '0;
        end
        else if (in_frame && (rx_byte == rcfp_pkg::CHAR_Z))
        begin
            if (phase_reg != rcfp_pkg::JOY_COL_START && phase_reg != rcfp_pkg::JOY_MISS_NONE)
            begin
                col_held_next = col_accum_reg;
            end
            if (phase_reg == rcfp_pkg::JOY_ROW_DIGITS || phase_reg == rcfp_pkg::JOY_BOTH)
            begin
                row_held_next = row_accum_reg;
            end
        end
        else if (in_frame && digit)
        begin
            case (phase_reg)
                rcfp_pkg::JOY_COL_START:  col_accum_next = acc_step('0, rx_byte);
                rcfp_pkg::JOY_COL_DIGITS: col_accum_next = acc_step(col_accum_reg, rx_byte);
                rcfp_pkg::JOY_ROW_START:  row_accum_next = acc_step('0, rx_byte);
                rcfp_pkg::JOY_ROW_DIGITS: row_accum_next = acc_step(row_accum_reg, rx_byte);
                default:
                begin
                    col_accum_next = col_accum_reg;
                    row_accum_next = row_accum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            length_reg <= '0;
            phase_reg <= rcfp_pkg::JOY_COL_START;
            col_accum_reg <= '0;
            row_accum_reg <= '0;
            col_held_reg <= '0;
            row_held_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            length_reg <= length_next;
            phase_reg <= phase_next;
            col_accum_reg <= col_accum_next;
            row_accum_reg <= row_accum_next;
            col_held_reg <= col_held_next;
            row_held_reg <= row_held_next;
        end
    end

endmodule

>>> hdl/rcfp_pump_track.sv
// Pump frame tracker: frame length, field matching and held pump value.
module rcfp_pump_track #(
    parameter int FRAME_LIMIT = 31,
    parameter int VALUE_MAX = 9999,
    localparam int LW = $clog2(FRAME_LIMIT + 1),
    localparam int VW = $clog2(VALUE_MAX + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output logic          done,
    output logic [VW-1:0] pump_held_next
);

    localparam logic [LW-1:0] LEN_LIMIT = LW'(FRAME_LIMIT);
    localparam logic [VW+3:0] SUM_MAX = (VW + 4)'(VALUE_MAX);

    function automatic logic [VW-1:0] acc_step(input logic [VW-1:0] acc,
                                               input logic [7:0] b);
        logic [VW+3:0] sum;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VW{1'b0}}, b[3:0]};
        return (sum > SUM_MAX) ? VW'(VALUE_MAX) : sum[VW-1:0];
    endfunction

    logic                  active_reg, active_next;
    logic [LW-1:0]         length_reg, length_next;
    rcfp_pkg::pump_phase_t phase_reg, phase_next;
    logic [VW-1:0]         accum_reg, accum_next;
    logic [VW-1:0]         held_reg;
    logic                  digit;
    logic                  in_frame;

    assign digit = rcfp_pkg::is_digit(rx_byte);
    assign in_frame = step && active_reg && (length_reg < LEN_LIMIT);

    // Frame control and field matching phase.
    always_comb
    begin
        active_next = active_reg;
        length_next = length_reg;
        phase_next = phase_reg;
        done = 1'b0;
        if (step)
        begin
            if (!active_reg)
            begin
                if (rx_byte == rcfp_pkg::CHAR_B)
                begin
                    active_next = 1'b1;
                    length_next = LW'(1);
                    phase_next = rcfp_pkg::PUMP_START;
                end
            end
            else if (length_reg >= LEN_LIMIT)
            begin
                active_next = 1'b0;
                length_next = '0;
            end
            else if (rx_byte == rcfp_pkg::CHAR_Z)
            begin
                active_next = 1'b0;
                length_next = '0;
                done = 1'b1;
            end
            else
            begin
                length_next = length_reg + LW'(1);
                case (phase_reg)
                    rcfp_pkg::PUMP_START:
                        phase_next = digit ? rcfp_pkg::PUMP_DIGITS : rcfp_pkg::PUMP_MISS;
                    rcfp_pkg::PUMP_DIGITS:
                        if (!digit)
                        begin
                            phase_next = rcfp_pkg::PUMP_FINISHED;
                        end
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // Digit accumulation and held value.
    always_comb
    begin
        accum_next = accum_reg;
        pump_held_next = held_reg;
        if (step && !active_reg && (rx_byte == rcfp_pkg::CHAR_B))
        begin
            accum_next = '0;
        end
        else if (in_frame && (rx_byte == rcfp_pkg::CHAR_Z))
        begin
            if (phase_reg == rcfp_pkg::PUMP_DIGITS || phase_reg == rcfp_pkg::PUMP_FINISHED)
            begin
                pump_held_next = accum_reg;
            end
        end
        else if (in_frame && digit)
        begin
            case (phase_reg)
                rcfp_pkg::PUMP_START:  accum_next = acc_step('0, rx_byte);
                rcfp_pkg::PUMP_DIGITS: accum_next = acc_step(accum_reg, rx_byte);
                default:               accum_next = accum_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            length_reg <= '0;
            phase_reg <= rcfp_pkg::PUMP_START;
            accum_reg <= '0;
            held_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            length_reg <= length_next;
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            held_reg <= pump_held_next;
        end
    end

endmodule

>>> hdl/rcfp_deadband.sv
// Dead band: snaps a held stick value strictly inside the band to the center value.
module rcfp_deadband #(
    parameter int VW = 14,
    localparam int BW = (VW > rcfp_pkg::VALUE_BITS) ? VW : rcfp_pkg::VALUE_BITS
) (
    input  logic [VW-1:0]                   value,
    input  logic [rcfp_pkg::VALUE_BITS-1:0] band_low,
    input  logic [rcfp_pkg::VALUE_BITS-1:0] band_high,
    input  logic [rcfp_pkg::VALUE_BITS-1:0] band_center,
    output logic [rcfp_pkg::VALUE_BITS-1:0] banded
);

    logic [BW-1:0] value_ext;
    logic [BW-1:0] low_ext;
    logic [BW-1:0] high_ext;
    logic [BW-1:0] center_ext;
    logic [BW-1:0] result;

    assign value_ext = BW'(value);
    assign low_ext = BW'(band_low);
    assign high_ext = BW'(band_high);
    assign center_ext = BW'(band_center);
    assign result = ((value_ext > low_ext) && (value_ext < high_ext)) ? center_ext : value_ext;
    assign banded = result[rcfp_pkg::VALUE_BITS-1:0];

endmodule

>>> hdl/remote_command_frame_parser.sv
// Top level of the remote command frame parser: input register, trackers and result register.
//
// Received bytes enter on byte_chan, one request per byte. Two trackers watch the stream:
// the joystick frame 'A' col ',' row 'Z' and the pump frame 'B' draw 'Z'. A byte that ends
// at least one frame produces one request on result_chan carrying both done flags and the
// current held values, the stick values passed through the dead band. Other bytes produce
// nothing. The dead band registers are written through cfg_we, cfg_index and cfg_data, and
// should only change while no byte is in flight.
// A result request becomes valid once its byte has passed the input register and then the result
// register; a stall on result_chan can hold the byte in the input register. Throughput is one
// byte per cycle while result_chan does not stall; the trackers update their state for a byte as
// it moves from the input register into the result register.
// When result_chan stalls, the result register holds and the input register fills; byte_chan
// then drops ready until the result is taken, so no request is lost or repeated.
// Reset clears both trackers, the held values and pending requests, and loads the dead band
// registers with 45, 55 and 50.
module remote_command_frame_parser #(
    parameter int FRAME_LIMIT = 31,
    parameter int VALUE_MAX = 9999
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rcfp_byte_if.sink                           byte_chan,
    rcfp_result_if.source                       result_chan,
    input  logic                                cfg_we,
    input  logic [rcfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rcfp_pkg::VALUE_BITS-1:0]     cfg_data
);

    localparam int VW = $clog2(VALUE_MAX + 1);
    localparam int PW = (VW > rcfp_pkg::VALUE_BITS) ? VW : rcfp_pkg::VALUE_BITS;

    logic [rcfp_pkg::VALUE_BITS-1:0] band_low_reg;
    logic [rcfp_pkg::VALUE_BITS-1:0] band_high_reg;
    logic [rcfp_pkg::VALUE_BITS-1:0] band_center_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   res_valid_reg;
    rcfp_pkg::result_item_t res_reg;
    rcfp_pkg::result_item_t res_next;

    logic          advance;
    logic          step;
    logic          joy_done;
    logic          pump_done;
    logic [VW-1:0] col_held_next;
    logic [VW-1:0] row_held_next;
    logic [VW-1:0] pump_held_next;
    logic [PW-1:0] pump_ext;
    logic [rcfp_pkg::VALUE_BITS-1:0] col_banded;
    logic [rcfp_pkg::VALUE_BITS-1:0] row_banded;

    assign advance = !res_valid_reg || result_chan.ready;
    assign step = in_valid_reg && advance;
    assign byte_chan.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg <= rcfp_pkg::DEADBAND_LOW_RESET;
            band_high_reg <= rcfp_pkg::DEADBAND_HIGH_RESET;
            band_center_reg <= rcfp_pkg::DEADBAND_CENTER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcfp_pkg::CFG_DEADBAND_LOW:    band_low_reg <= cfg_data;
                rcfp_pkg::CFG_DEADBAND_HIGH:   band_high_reg <= cfg_data;
                rcfp_pkg::CFG_DEADBAND_CENTER: band_center_reg <= cfg_data;
                default:                       band_low_reg <= band_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            in_valid_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_chan.ready && byte_chan.valid)
        begin
            in_byte_reg <= byte_chan.payload.rx_byte;
        end
    end

    rcfp_joy_track #(
        .FRAME_LIMIT (FRAME_LIMIT),
        .VALUE_MAX   (VALUE_MAX)
    ) u_joy (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .done          (joy_done),
        .col_held_next (col_held_next),
        .row_held_next (row_held_next)
    );

    rcfp_pump_track #(
        .FRAME_LIMIT (FRAME_LIMIT),
        .VALUE_MAX   (VALUE_MAX)
    ) u_pump (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .rx_byte        (in_byte_reg),
        .done           (pump_done),
        .pump_held_next (pump_held_next)
    );

    rcfp_deadband #(
        .VW (VW)
    ) u_col_band (
        .value       (col_held_next),
        .band_low    (band_low_reg),
        .band_high   (band_high_reg),
        .band_center (band_center_reg),
        .banded      (col_banded)
    );

    rcfp_deadband #(
        .VW (VW)
    ) u_row_band (
        .value       (row_held_next),
        .band_low    (band_low_reg),
        .band_high   (band_high_reg),
        .band_center (band_center_reg),
        .banded      (row_banded)
    );

    assign pump_ext = PW'(pump_held_next);

    always_comb
    begin
        res_next.joy_done = joy_done;
        res_next.col_value = col_banded;
        res_next.row_value = row_banded;
        res_next.pump_done = pump_done;
        res_next.pump_value = pump_ext[rcfp_pkg::VALUE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= step && (joy_done || pump_done);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result_chan.valid = res_valid_reg;
    assign result_chan.payload = res_reg;

endmodule
